/* hdl/sidau_pkg.sv */
`timescale 1ns / 1ps

package sidau_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitIdxW = $clog2(NumDigits);

  localparam logic [CharW-1:0]  CharZero  = 6'd48;
  localparam logic [CharW-1:0]  CharMinus = 6'd45;
  localparam logic [DigitW-1:0] Radix     = 4'd10;

  // floor(x / 10) == (x * Recip10) >> Recip10Shift for every 32-bit x
  localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned       Recip10Shift = 35;

  typedef struct packed {
    logic [ValueW-1:0] quot;
    logic [DigitW-1:0] rem;
  } div10_t;

endpackage : sidau_pkg

/* hdl/sidau_div10.sv */
`timescale 1ns / 1ps

// One divide-by-ten step: reciprocal multiply, then remainder by shift-add.
module sidau_div10 import sidau_pkg::*; (
  input  logic [ValueW-1:0] dividend_i,
  output div10_t            res_o
);

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   quot_x10;
  logic [ValueW-1:0]   diff;

  assign prod     = {{ValueW{1'b0}}, dividend_i} * {{ValueW{1'b0}}, Recip10};
  assign quot     = ValueW'(prod >> Recip10Shift);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign diff     = dividend_i - quot_x10;

  assign res_o.quot = quot;
  assign res_o.rem  = diff[DigitW-1:0];

endmodule : sidau_div10

/* hdl/signed_int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text. Each input word is one
// two's-complement value; the block answers with its text one character
// word at a time, most significant digit first, a leading '-' for negative
// values, no leading zeros (zero prints as a single '0'), and last_char_o
// set on the final character. The most negative value prints in full as
// "-2147483648". The value is registered on acceptance; the shared
// divide-by-ten unit (reciprocal multiply) then yields one digit per
// cycle, and the characters follow through the output register at one
// per cycle while the receiver does not stall. in_stall_o is high from
// acceptance until the last character has been loaded into the output
// register; that character may still be waiting downstream while the
// next value is accepted.
module signed_int_to_decimal_ascii_unit import sidau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ValueW-1:0] value_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CharW-1:0]         char_code_o,
  output logic                     last_char_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e               state_q;
  logic [ValueW-1:0]    mag_q;
  logic                 neg_q;
  logic [DigitIdxW-1:0] cnt_q;      // digits produced so far
  logic [DigitIdxW-1:0] idx_q;      // next digit to print
  logic [DigitW-1:0]    digit_q [NumDigits];

  logic                 out_valid_q;
  logic [CharW-1:0]     char_q;
  logic                 last_q;

  div10_t               div_res;
  logic                 in_fire;
  logic                 out_free;
  logic                 emit;
  logic [ValueW-1:0]    value_raw;
  logic [ValueW-1:0]    mag_in;

  sidau_div10 u_div10 (
    .dividend_i (mag_q),
    .res_o      (div_res)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  // output register may take a new character this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // a character is loaded into the output register this cycle
  assign emit       = (state_q == StEmit) && out_free;

  // unsigned magnitude, so the most negative value needs no special case
  assign value_raw = $unsigned(value_i);
  assign mag_in    = value_raw[ValueW-1] ? (~value_raw + ValueW'(1)) : value_raw;

  // digit store: written LSD first during division, read back MSD first
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv) begin
      digit_q[cnt_q] <= div_res.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            mag_q   <= mag_in;
            neg_q   <= value_raw[ValueW-1];
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          mag_q <= div_res.quot;
          cnt_q <= cnt_q + DigitIdxW'(1);
          if (div_res.quot == '0 || cnt_q == DigitIdxW'(NumDigits - 1)) begin
            idx_q   <= cnt_q;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit) begin
            if (neg_q) begin
              char_q <= CharMinus;
              last_q <= 1'b0;
              neg_q  <= 1'b0;
            end else begin
              char_q <= CharZero + CharW'(digit_q[idx_q]);
              last_q <= (idx_q == '0);
              if (idx_q == '0) begin
                state_q <= StIdle;
              end else begin
                idx_q <= idx_q - DigitIdxW'(1);
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // divide step always yields a decimal digit
  a_rem_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> div_res.rem < Radix)
    else $error("divide-by-ten remainder out of range");

  // digit count never runs past the digit store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> cnt_q < DigitIdxW'(NumDigits))
    else $error("digit counter overran digit store");

  // only minus or digit codes leave the block
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CharMinus ||
                     (char_code_o >= CharZero &&
                      char_code_o <= CharZero + CharW'(Radix - 4'd1))))
    else $error("illegal character code");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o == CharMinus |-> !last_char_o)
    else $error("minus sign flagged as last character");

  // accepted value goes straight into division
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == StDiv)
    else $error("accepted value did not start division");

endmodule : signed_int_to_decimal_ascii_unit

/* dv/tb.sv */
`timescale 1ns / 1ps

// Testbench for the signed integer to decimal ASCII unit.
// Each word sent in is one 32-bit value. The text it should print is worked
// out when the word is accepted and queued one character word at a time.
// The output monitor pops that queue for every character the block hands
// out and compares the character code and the last flag.
module tb;
  import sidau_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 7;
  localparam int CycleLimit  = 200_000;
  localparam int DrainCycles = 40;
  localparam int RandPerMix  = 34;

  // One character word as the output channel moves it.
  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } char_word_t;

  // Directed stimulus. An empty text means the expected text is predicted.
  typedef struct {
    logic [ValueW-1:0] value;
    string             text;
  } text_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [ValueW-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [CharW-1:0]         char_code_o;
  logic                     last_char_o;

  // Characters still owed by the block, oldest first.
  char_word_t  pending_chars[$];
  text_row_t   directed_rows[20];

  int unsigned mismatches;
  int unsigned chars_checked;
  int unsigned words_sent;
  int unsigned negative_words;
  int unsigned ten_digit_words;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always #ClkHalf clk_i = ~clk_i;

  signed_int_to_decimal_ascii_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Decimal text of a two's-complement value: sign first, then the digits
  // of the unsigned magnitude from the most significant down. The magnitude
  // is unsigned so the most negative value negates to 2147483648.
  task automatic predict_text(input logic [ValueW-1:0] raw);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digits[NumDigits];
    int                n;
    mag = raw[ValueW-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      digits[n] = DigitW'(mag % ValueW'(Radix));
      mag       = mag / ValueW'(Radix);
      n++;
    end while (mag != 0 && n < NumDigits);
    if (raw[ValueW-1]) begin
      pending_chars.push_back('{code: CharMinus, last: 1'b0});
    end
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{code: CharZero + CharW'(digits[k]), last: (k == 0)});
    end
  endtask

  // Expected text typed in by hand, e.g. "-2147483648".
  task automatic queue_typed_text(input string s);
    byte ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      pending_chars.push_back('{code: ch[CharW-1:0], last: (i == s.len() - 1)});
    end
  endtask

  // Random value: full 32-bit noise, powers of ten and their neighbors
  // below, or a value with a chosen number of digits. Random sign except
  // for the noise case, which carries its own.
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned       ndig;
    longint unsigned   pow;
    longint unsigned   hi;
    logic [ValueW-1:0] mag;
    ndig = $urandom_range(10, 1);
    pow  = 1;
    repeat (ndig - 1) pow = pow * 10;
    case ($urandom_range(4))
      0: begin
        return $urandom;
      end
      1: begin
        mag = ValueW'(pow - $urandom_range(1, 0));
      end
      default: begin
        hi = pow * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = $urandom_range(32'(hi), (ndig == 1) ? 32'd0 : 32'(pow));
      end
    endcase
    if ($urandom_range(1)) return ~mag + 1'b1;
    return mag;
  endfunction

  // Send one word. While idle the payload wanders; once valid is up it
  // holds until the word is taken. Expectations are queued on acceptance,
  // before the first character can come out.
  task automatic send_word(input logic [ValueW-1:0] v, input string text);
    int n_prior;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    n_prior = pending_chars.size();
    if (text.len() == 0) predict_text(v);
    else queue_typed_text(text);
    words_sent++;
    if (v[ValueW-1]) negative_words++;
    if (pending_chars.size() - n_prior - int'(v[ValueW-1]) == NumDigits) begin
      ten_digit_words++;
    end
  endtask

  // Hold the input off until every owed character has come out.
  task automatic drain_all();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Output monitor and receiver stall. Sampling right after the edge sees
  // the values that the edge itself used.
  always @(posedge clk_i) begin
    char_word_t got;
    char_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{code: char_code_o, last: last_char_o};
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d last %0b", got.code, got.last));
      end else begin
        want = pending_chars.pop_front();
        if (got.code !== want.code) begin
          report_mismatch($sformatf("char_code %0d, expected %0d", got.code, want.code));
        end
        if (got.last !== want.last) begin
          report_mismatch($sformatf("last_char %0b, expected %0b (char %0d)",
                                    got.last, want.last, want.code));
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d chars still owed",
               CycleLimit, pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    chars_checked = 0;
    words_sent    = 0;
    negative_words  = 0;
    ten_digit_words = 0;
    cycle_count   = 0;
    send_idle_pct = 21;
    recv_idle_pct = 45;

    // Extremes, zero, digit-count boundaries, the most negative value and
    // alternating bit patterns.
    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'hFFFF_FFFF,  "-1"},
      '{32'hFFFF_FFF7,  "-9"},
      '{32'hFFFF_FFF6,  "-10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  ""},
      '{32'hC465_3600,  ""},
      '{32'd1234567890, ""},
      '{32'hB669_FD2E,  ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'd2000000000, ""}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First mix: sender idles now and then, receiver stalls a lot.
    foreach (directed_rows[i]) send_word(directed_rows[i].value, directed_rows[i].text);
    repeat (RandPerMix) send_word(pick_value(), "");
    drain_all();

    // Second mix: the other way round, starting from an empty pipe.
    send_idle_pct = 45;
    recv_idle_pct = 21;
    repeat (RandPerMix) send_word(pick_value(), "");
    drain_all();

    // Third mix: back to back at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RandPerMix) send_word(pick_value(), "");
    drain_all();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words (%0d negative, %0d with ten digits), checked %0d characters",
             words_sent, negative_words, ten_digit_words, chars_checked);
    $display("under three sender/receiver idle mixes; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
